/* rtl/assert_macros.svh */
// Assertion macros shared by the coalescer RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising edge outside reset
`define SGDC_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Invariant checked at every rising edge outside reset
`define SGDC_ASSERT_ALW(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

`endif

/* rtl/sgdc_pkg.sv */
// Types and constants of the scatter-gather descriptor coalescer
package sgdc_pkg;

  localparam logic [31:0] EP_START_RESET   = 32'd4096;
  localparam logic [7:0]  DESC_LIMIT_RESET = 8'd25;

  localparam logic [7:0] CFG_EP_START   = 8'd0;
  localparam logic [7:0] CFG_DESC_LIMIT = 8'd1;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;
  localparam int FIFO_CW    = 3;

  typedef struct packed {
    logic [63:0] seg_addr;
    logic [31:0] seg_len;
    logic        seg_first;
    logic        seg_last;
  } seg_t;

  typedef struct packed {
    logic [7:0]  desc_index;
    logic [29:0] desc_words;
    logic [31:0] desc_ep_addr;
    logic [63:0] desc_host_addr;
    logic        desc_final;
    logic        segs_dropped;
    logic        len_misaligned;
  } desc_t;

  typedef struct packed {
    logic [31:0] ep_start;
    logic [7:0]  slot_lim;
  } cfg_t;

  typedef struct packed {
    logic [1:0] n;
    desc_t      d0;
    desc_t      d1;
  } push_t;

  typedef struct packed {
    logic               space;
    logic [FIFO_CW-1:0] level;
  } fifo_stat_t;

endpackage

/* rtl/sgdc_seg_if.sv */
// Segment input channel
interface sgdc_seg_if;
  logic        valid;
  logic        ready;
  logic [63:0] seg_addr;
  logic [31:0] seg_len;
  logic        seg_first;
  logic        seg_last;

  modport source (output valid, seg_addr, seg_len, seg_first, seg_last, input ready);
  modport sink   (input valid, seg_addr, seg_len, seg_first, seg_last, output ready);
endinterface

/* rtl/sgdc_desc_if.sv */
// Descriptor output channel
interface sgdc_desc_if;
  logic        valid;
  logic        ready;
  logic [7:0]  desc_index;
  logic [29:0] desc_words;
  logic [31:0] desc_ep_addr;
  logic [63:0] desc_host_addr;
  logic        desc_final;
  logic        segs_dropped;
  logic        len_misaligned;

  modport source (output valid, desc_index, desc_words, desc_ep_addr, desc_host_addr,
                  desc_final, segs_dropped, len_misaligned, input ready);
  modport sink   (input valid, desc_index, desc_words, desc_ep_addr, desc_host_addr,
                  desc_final, segs_dropped, len_misaligned, output ready);
endinterface

/* rtl/sgdc_cfg_if.sv */
// Configuration write channel
interface sgdc_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/sg_descriptor_coalescer_top.sv */
// Path: a segment beat is registered in the input register, merged from there and pushed
// into the descriptor queue, whose registered head drives the output.
// Throughput: one segment per cycle while the queue has room and each yields at most one
// descriptor; a segment that closes a run and ends the list yields two, sent in turn.
// The four-entry descriptor queue sets how far the output may stall before input stops.
// Reset clears list state and queue; ep_start returns to 4096 and desc_limit to 25.
`include "assert_macros.svh"

module sg_descriptor_coalescer_top import sgdc_pkg::*; #(
  parameter int MAX_TABLE_DESC = 255
) (
  input  logic        clk,
  input  logic        rst,
  sgdc_seg_if.sink    seg,
  sgdc_desc_if.source desc,
  sgdc_cfg_if.sink    cfg
);

  cfg_t       cfg_cur;
  push_t      push;
  fifo_stat_t stat;

  sgdc_cfg_regs #(.MAX_TABLE_DESC(MAX_TABLE_DESC)) u_cfg (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .cfg_out (cfg_cur)
  );

  sgdc_step u_step (
    .clk   (clk),
    .rst   (rst),
    .seg   (seg),
    .cfg   (cfg_cur),
    .space (stat.space),
    .push  (push)
  );

  sgdc_out_fifo u_fifo (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .desc (desc),
    .stat (stat)
  );

  `SGDC_ASSERT_ALW(a_level_bound, clk, rst, stat.level <= FIFO_CW'(FIFO_DEPTH), "queue overrun")
  `SGDC_ASSERT_IMP(a_pair_order, clk, rst, push.n == 2'd2, !push.d0.desc_final && push.d1.desc_final, "pair order wrong")
  `SGDC_ASSERT_IMP(a_pair_index, clk, rst, push.n == 2'd2, push.d1.desc_index == push.d0.desc_index + 8'd1, "pair index gap")
  `SGDC_ASSERT_IMP(a_push_room, clk, rst, push.n != 2'd0, stat.level <= FIFO_CW'(FIFO_DEPTH - 2), "push without room")

endmodule

/* rtl/sgdc_cfg_regs.sv */
// Configuration registers and slot limit of the coalescer
module sgdc_cfg_regs import sgdc_pkg::*; #(
  parameter int MAX_TABLE_DESC = 255
) (
  input  logic       clk,
  input  logic       rst,
  sgdc_cfg_if.sink   cfg,
  output cfg_t       cfg_out
);

  localparam logic [7:0] MaxDesc = 8'(MAX_TABLE_DESC);

  logic [31:0] ep_start;
  logic [7:0]  desc_limit;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ep_start   <= EP_START_RESET;
      desc_limit <= DESC_LIMIT_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_EP_START:   ep_start   <= cfg.data;
        CFG_DESC_LIMIT: desc_limit <= cfg.data[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_out.ep_start = ep_start;
    priority if (desc_limit == 8'd0) begin
      cfg_out.slot_lim = 8'd1;
    end else if (desc_limit > MaxDesc) begin
      cfg_out.slot_lim = MaxDesc;
    end else begin
      cfg_out.slot_lim = desc_limit;
    end
  end

endmodule

/* rtl/sgdc_step.sv */
// Input register, list state and per-segment merge logic
module sgdc_step import sgdc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  sgdc_seg_if.sink seg,
  input  cfg_t     cfg,
  input  logic     space,
  output push_t    push
);

  logic        in_valid;
  seg_t        in_q;
  logic        fire;

  logic [63:0] run_addr;
  logic [31:0] run_len;
  logic [31:0] ep_next;
  logic [7:0]  desc_count;
  logic        dropping;
  logic        misaligned_seen;
  logic        run_open;

  logic [63:0] run_addr_next;
  logic [31:0] run_len_next;
  logic [31:0] ep_next_next;
  logic [7:0]  desc_count_next;
  logic        dropping_next;
  logic        misaligned_seen_next;
  logic        run_open_next;

  logic        f_open, f_drop, f_mis;
  logic [63:0] f_addr;
  logic [31:0] f_len, f_ep;
  logic [7:0]  f_cnt;
  logic [31:0] len;
  logic [63:0] run_end;
  logic [32:0] sum;
  logic        contig, room_a, emit_a, emit_b, taken, open_n;
  logic [7:0]  cnt_a;
  logic [31:0] ep_a;
  desc_t       rec_a, rec_b;

  assign fire      = in_valid && space;
  assign seg.ready = !in_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (seg.ready) begin
      in_valid <= seg.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (seg.valid && seg.ready) begin
      in_q <= '{seg_addr: seg.seg_addr, seg_len: seg.seg_len,
                seg_first: seg.seg_first, seg_last: seg.seg_last};
    end
  end

  always_comb begin
    f_open = in_q.seg_first ? 1'b0 : run_open;
    f_drop = in_q.seg_first ? 1'b0 : dropping;
    f_mis  = in_q.seg_first ? 1'b0 : misaligned_seen;
    f_addr = in_q.seg_first ? 64'd0 : run_addr;
    f_len  = in_q.seg_first ? 32'd0 : run_len;
    f_ep   = in_q.seg_first ? cfg.ep_start : ep_next;
    f_cnt  = in_q.seg_first ? 8'd0 : desc_count;

    len     = {in_q.seg_len[31:2], 2'b00};
    run_end = f_addr + {32'd0, f_len};
    sum     = {1'b0, f_len} + {1'b0, len};
    contig  = (in_q.seg_addr == run_end) && !sum[32];
    room_a  = ({1'b0, f_cnt} + 9'd1) < {1'b0, cfg.slot_lim};

    emit_a        = 1'b0;
    taken         = 1'b0;
    dropping_next = f_drop;
    open_n        = f_open;
    run_addr_next = f_addr;
    run_len_next  = f_len;

    if (!f_drop) begin
      if (f_open) begin
        priority if (contig) begin
          run_len_next = sum[31:0];
          taken        = 1'b1;
        end else if (room_a) begin
          emit_a        = 1'b1;
          run_addr_next = in_q.seg_addr;
          run_len_next  = len;
          taken         = 1'b1;
        end else begin
          dropping_next = 1'b1;
        end
      end else if (f_cnt < cfg.slot_lim) begin
        open_n        = 1'b1;
        run_addr_next = in_q.seg_addr;
        run_len_next  = len;
        taken         = 1'b1;
      end else begin
        dropping_next = 1'b1;
      end
    end

    misaligned_seen_next = f_mis || (taken && (in_q.seg_len[1:0] != 2'b00));

    cnt_a  = emit_a ? f_cnt + 8'd1 : f_cnt;
    ep_a   = emit_a ? f_ep + f_len : f_ep;
    emit_b = in_q.seg_last && open_n;

    desc_count_next = emit_b ? cnt_a + 8'd1 : cnt_a;
    ep_next_next    = emit_b ? ep_a + run_len_next : ep_a;
    run_open_next   = open_n && !emit_b;

    rec_a = '{desc_index: f_cnt, desc_words: f_len[31:2], desc_ep_addr: f_ep,
              desc_host_addr: f_addr, desc_final: 1'b0, segs_dropped: f_drop,
              len_misaligned: f_mis};
    rec_b = '{desc_index: cnt_a, desc_words: run_len_next[31:2], desc_ep_addr: ep_a,
              desc_host_addr: run_addr_next, desc_final: 1'b1,
              segs_dropped: dropping_next, len_misaligned: misaligned_seen_next};

    push.n  = fire ? ({1'b0, emit_a} + {1'b0, emit_b}) : 2'd0;
    push.d0 = emit_a ? rec_a : rec_b;
    push.d1 = rec_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_addr        <= 64'd0;
      run_len         <= 32'd0;
      ep_next         <= 32'd0;
      desc_count      <= 8'd0;
      dropping        <= 1'b0;
      misaligned_seen <= 1'b0;
      run_open        <= 1'b0;
    end else if (fire) begin
      run_addr        <= run_addr_next;
      run_len         <= run_len_next;
      ep_next         <= ep_next_next;
      desc_count      <= desc_count_next;
      dropping        <= dropping_next;
      misaligned_seen <= misaligned_seen_next;
      run_open        <= run_open_next;
    end
  end

endmodule

/* rtl/sgdc_out_fifo.sv */
// Descriptor queue taking up to two entries per cycle
module sgdc_out_fifo import sgdc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  push_t       push,
  sgdc_desc_if.source desc,
  output fifo_stat_t  stat
);

  desc_t              mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;
  logic [FIFO_CW-1:0] count;
  logic [FIFO_CW-1:0] count_next;
  logic               pop;
  desc_t              head;

  assign pop        = desc.valid && desc.ready;
  assign count_next = count + FIFO_CW'(push.n) - FIFO_CW'(pop);
  assign stat.space = count <= FIFO_CW'(FIFO_DEPTH - 2);
  assign stat.level = count;

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      mem[wr_ptr] <= push.d0;
    end
    if (push.n == 2'd2) begin
      mem[wr_ptr + FIFO_AW'(1)] <= push.d1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + FIFO_AW'(push.n);
      rd_ptr <= rd_ptr + FIFO_AW'(pop);
      count  <= count_next;
    end
  end

  assign head                = mem[rd_ptr];
  assign desc.valid          = count != '0;
  assign desc.desc_index     = head.desc_index;
  assign desc.desc_words     = head.desc_words;
  assign desc.desc_ep_addr   = head.desc_ep_addr;
  assign desc.desc_host_addr = head.desc_host_addr;
  assign desc.desc_final     = head.desc_final;
  assign desc.segs_dropped   = head.segs_dropped;
  assign desc.len_misaligned = head.len_misaligned;

endmodule

/* dv/tb_sg_descriptor_coalescer_top.sv */
// Self-checking testbench for the scatter-gather descriptor coalescer
module tb_sg_descriptor_coalescer_top;
  import sgdc_pkg::*;

  localparam int TABLE_SLOTS = 255;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES = 150;
  localparam int RANDOM_PHASES = 6;
  localparam int SEGS_PER_PHASE = 100;

  typedef struct {
    bit          is_cfg;
    logic [7:0]  reg_idx;
    logic [31:0] reg_data;
    seg_t        seg;
    bit          typed;
    desc_t       want;
  } step_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  sgdc_seg_if  seg_ch();
  sgdc_desc_if desc_ch();
  sgdc_cfg_if  cfg_ch();

  sg_descriptor_coalescer_top #(.MAX_TABLE_DESC(TABLE_SLOTS)) dut (
    .clk(clk),
    .rst(rst),
    .seg(seg_ch),
    .desc(desc_ch),
    .cfg(cfg_ch)
  );

  always #2 clk = ~clk;

  // Coalescer shadow: register copies and list state
  logic [31:0] ep_start_reg;
  logic [7:0]  lim_reg;
  logic [63:0] open_addr;
  logic [31:0] open_bytes;
  logic [31:0] ep_cursor;
  logic [7:0]  table_fill;
  bit          list_dropping;
  bit          odd_len_seen;
  bit          run_active;

  desc_t       expected_descs[$];
  step_row_t   directed_rows[$];

  int send_quiet = 0;
  int recv_quiet = 0;
  bit hold_req = 1'b0;
  int errors = 0;
  int segs_taken = 0;
  int segs_ignored = 0;
  int ragged_lens = 0;
  int descs_checked = 0;
  int cfg_writes = 0;

  function automatic int draw_wait(ref int quiet_left);
    if (quiet_left > 0) begin
      quiet_left--;
      return 0;
    end
    if ($urandom_range(0, 24) == 0) quiet_left = $urandom_range(8, 40);
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 17);
  endfunction

  function automatic void close_run(bit final_flag);
    desc_t d;
    d.desc_index     = table_fill;
    d.desc_words     = open_bytes[31:2];
    d.desc_ep_addr   = ep_cursor;
    d.desc_host_addr = open_addr;
    d.desc_final     = final_flag;
    d.segs_dropped   = list_dropping;
    d.len_misaligned = odd_len_seen;
    expected_descs.push_back(d);
    ep_cursor  = ep_cursor + open_bytes;
    table_fill = table_fill + 8'd1;
  endfunction

  function automatic bit coalesce_segment(seg_t s);
    logic [31:0] trimmed;
    int          lim;
    bit          took;
    trimmed = {s.seg_len[31:2], 2'b00};
    lim = (lim_reg == 8'd0) ? 1 : int'(lim_reg);
    if (lim > TABLE_SLOTS) lim = TABLE_SLOTS;
    took = 1'b0;
    if (s.seg_first) begin
      run_active    = 1'b0;
      open_addr     = '0;
      open_bytes    = '0;
      table_fill    = '0;
      ep_cursor     = ep_start_reg;
      list_dropping = 1'b0;
      odd_len_seen  = 1'b0;
    end
    if (!list_dropping) begin
      if (run_active) begin
        if (s.seg_addr == open_addr + {32'd0, open_bytes} &&
            32'(open_bytes + trimmed) >= open_bytes) begin
          open_bytes = open_bytes + trimmed;
          took = 1'b1;
        end else if (int'(table_fill) + 1 < lim) begin
          close_run(1'b0);
          open_addr  = s.seg_addr;
          open_bytes = trimmed;
          took = 1'b1;
        end else begin
          list_dropping = 1'b1;
        end
      end else if (int'(table_fill) < lim) begin
        run_active = 1'b1;
        open_addr  = s.seg_addr;
        open_bytes = trimmed;
        took = 1'b1;
      end else begin
        list_dropping = 1'b1;
      end
    end
    if (took && s.seg_len[1:0] != 2'b00) odd_len_seen = 1'b1;
    if (s.seg_last && run_active) begin
      close_run(1'b1);
      run_active = 1'b0;
    end
    return took;
  endfunction

  function automatic void add_seg(logic [63:0] addr, logic [31:0] len, bit first, bit last,
                                  bit typed = 1'b0, desc_t want = '0);
    step_row_t r;
    r.is_cfg         = 1'b0;
    r.reg_idx        = '0;
    r.reg_data       = '0;
    r.seg.seg_addr   = addr;
    r.seg.seg_len    = len;
    r.seg.seg_first  = first;
    r.seg.seg_last   = last;
    r.typed          = typed;
    r.want           = want;
    directed_rows.push_back(r);
  endfunction

  function automatic void add_cfg(logic [7:0] idx, logic [31:0] data);
    step_row_t r;
    r.is_cfg   = 1'b1;
    r.reg_idx  = idx;
    r.reg_data = data;
    r.seg      = '0;
    r.typed    = 1'b0;
    r.want     = '0;
    directed_rows.push_back(r);
  endfunction

  // Call at a falling edge; returns at the falling edge after the beat
  task automatic push_segment(input seg_t s, input bit typed, input desc_t want);
    int gap;
    int base;
    bit took;
    gap = draw_wait(send_quiet);
    if (gap > 0) begin
      seg_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    seg_ch.valid     = 1'b1;
    seg_ch.seg_addr  = s.seg_addr;
    seg_ch.seg_len   = s.seg_len;
    seg_ch.seg_first = s.seg_first;
    seg_ch.seg_last  = s.seg_last;
    @(posedge clk);
    while (!seg_ch.ready) @(posedge clk);
    base = expected_descs.size();
    took = coalesce_segment(s);
    if (typed) expected_descs[base] = want;
    if (took) segs_taken++;
    else segs_ignored++;
    if (took && s.seg_len[1:0] != 2'b00) ragged_lens++;
    @(negedge clk);
  endtask

  task automatic write_register(input logic [7:0] idx, input logic [31:0] data);
    seg_ch.valid = 1'b0;
    while (expected_descs.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data  = data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    if (idx == CFG_EP_START) ep_start_reg = data;
    else if (idx == CFG_DESC_LIMIT) lim_reg = data[7:0];
    cfg_writes++;
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic send_random_list();
    int          n;
    int          pick;
    logic [63:0] addr;
    seg_t        s;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
    addr = {$urandom, $urandom};
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (i > 0 && pick >= 35) s.seg_addr = addr;
      else if (pick < 10) s.seg_addr = addr + 64'($urandom_range(1, 64) * 4);
      else s.seg_addr = {$urandom, $urandom};
      pick = $urandom_range(0, 99);
      if (pick < 60) s.seg_len = 32'($urandom_range(0, 64) * 4);
      else if (pick < 75) s.seg_len = 32'($urandom_range(0, 255));
      else if (pick < 90) s.seg_len = $urandom;
      else s.seg_len = ($urandom | 32'hF000_0000) & 32'hFFFF_FFFC;
      s.seg_first = (i == 0) ? ($urandom_range(0, 19) != 0) : ($urandom_range(0, 49) == 0);
      s.seg_last  = (i == n - 1) ? ($urandom_range(0, 19) != 0) : ($urandom_range(0, 49) == 0);
      addr = s.seg_addr + {32'd0, s.seg_len[31:2], 2'b00};
      push_segment(s, 1'b0, '0);
    end
  endtask

  // Descriptor sink and checker
  initial begin
    int    stall;
    desc_t got;
    desc_t want;
    string bad;
    desc_ch.ready = 1'b0;
    wait (rst === 1'b0);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        desc_ch.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      stall = draw_wait(recv_quiet);
      if (stall > 0) begin
        desc_ch.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      desc_ch.ready = 1'b1;
      @(posedge clk);
      while (!desc_ch.valid) @(posedge clk);
      got.desc_index     = desc_ch.desc_index;
      got.desc_words     = desc_ch.desc_words;
      got.desc_ep_addr   = desc_ch.desc_ep_addr;
      got.desc_host_addr = desc_ch.desc_host_addr;
      got.desc_final     = desc_ch.desc_final;
      got.segs_dropped   = desc_ch.segs_dropped;
      got.len_misaligned = desc_ch.len_misaligned;
      descs_checked++;
      if (expected_descs.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected descriptor: idx %0d words %h ep %h host %h",
                   got.desc_index, got.desc_words, got.desc_ep_addr, got.desc_host_addr);
      end else begin
        want = expected_descs.pop_front();
        bad = "";
        if (got.desc_index !== want.desc_index) bad = {bad, " index"};
        if (got.desc_words !== want.desc_words) bad = {bad, " words"};
        if (got.desc_ep_addr !== want.desc_ep_addr) bad = {bad, " ep_addr"};
        if (got.desc_host_addr !== want.desc_host_addr) bad = {bad, " host_addr"};
        if (got.desc_final !== want.desc_final) bad = {bad, " final"};
        if (got.segs_dropped !== want.segs_dropped) bad = {bad, " dropped"};
        if (got.len_misaligned !== want.len_misaligned) bad = {bad, " misaligned"};
        if (bad != "") begin
          errors++;
          if (errors <= 10) begin
            $display("descriptor mismatch in%s", bad);
            $display("  expected idx %0d words %h ep %h host %h fin %b drop %b mis %b",
                     want.desc_index, want.desc_words, want.desc_ep_addr, want.desc_host_addr,
                     want.desc_final, want.segs_dropped, want.len_misaligned);
            $display("  actual   idx %0d words %h ep %h host %h fin %b drop %b mis %b",
                     got.desc_index, got.desc_words, got.desc_ep_addr, got.desc_host_addr,
                     got.desc_final, got.segs_dropped, got.len_misaligned);
          end
        end
      end
    end
  end

  initial begin
    #4_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    logic [31:0] ep_val;
    logic [7:0]  lim_val;
    seg_ch.valid     = 1'b0;
    seg_ch.seg_addr  = '0;
    seg_ch.seg_len   = '0;
    seg_ch.seg_first = 1'b0;
    seg_ch.seg_last  = 1'b0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.index     = '0;
    cfg_ch.data      = '0;

    ep_start_reg  = EP_START_RESET;
    lim_reg       = DESC_LIMIT_RESET;
    open_addr     = '0;
    open_bytes    = '0;
    ep_cursor     = '0;
    table_fill    = '0;
    list_dropping = 1'b0;
    odd_len_seen  = 1'b0;
    run_active    = 1'b0;

    add_seg(64'h1000, 32'd16, 1, 1, 1,
            '{8'd0, 30'd4, 32'd4096, 64'h1000, 1'b1, 1'b0, 1'b0});
    add_seg(64'hFFFF_FFFF_FFFF_FFFC, 32'd4, 1, 0);
    add_seg(64'h0, 32'd8, 0, 1, 1,
            '{8'd0, 30'd3, 32'd4096, 64'hFFFF_FFFF_FFFF_FFFC, 1'b1, 1'b0, 1'b0});
    add_seg(64'h2000, 32'd7, 1, 0);
    add_seg(64'h3000, 32'hFFFF_FFFF, 0, 1);
    add_seg(64'h0, 32'hFFFF_FFFC, 1, 0);
    add_seg(64'hFFFF_FFFC, 32'd4, 0, 1);
    add_seg(64'h10, 32'd0, 1, 1, 1,
            '{8'd0, 30'd0, 32'd4096, 64'h10, 1'b1, 1'b0, 1'b0});
    add_seg(64'h20, 32'd3, 0, 0);
    add_seg(64'h20, 32'd12, 0, 1);
    add_seg(64'h5555_5555_5555_5554, 32'h5555_5554, 1, 0);
    add_seg(64'hAAAA_AAAA_AAAA_AAA8, 32'hAAAA_AAA8, 1, 1, 1,
            '{8'd0, 30'h2AAA_AAAA, 32'd4096, 64'hAAAA_AAAA_AAAA_AAA8, 1'b1, 1'b0, 1'b0});
    add_cfg(CFG_DESC_LIMIT, 32'hFFFF_FF01);
    add_cfg(CFG_EP_START, 32'hFFFF_FFFF);
    add_seg(64'h100, 32'd8, 1, 0);
    add_seg(64'h900, 32'd4, 0, 0);
    add_seg(64'h108, 32'd5, 0, 1, 1,
            '{8'd0, 30'd2, 32'hFFFF_FFFF, 64'h100, 1'b1, 1'b1, 1'b0});
    add_seg(64'h200, 32'd4, 0, 1);
    add_cfg(CFG_DESC_LIMIT, 32'h0);
    add_cfg(CFG_EP_START, 32'h0);
    add_seg(64'h300, 32'd8, 1, 0);
    add_seg(64'h400, 32'd8, 0, 1, 1,
            '{8'd0, 30'd2, 32'h0, 64'h300, 1'b1, 1'b1, 1'b0});
    add_cfg(CFG_DESC_LIMIT, 32'h0000_00FF);
    add_cfg(CFG_EP_START, 32'h8000_0000);
    add_seg(64'h1000, 32'd16, 1, 0);
    add_seg(64'h1010, 32'd16, 0, 0);
    add_seg(64'h4000, 32'd4, 0, 1);

    repeat (2) @(negedge clk);
    rst = 1'b0;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg)
        write_register(directed_rows[i].reg_idx, directed_rows[i].reg_data);
      else
        push_segment(directed_rows[i].seg, directed_rows[i].typed, directed_rows[i].want);
    end

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: begin ep_val = $urandom; lim_val = 8'd2; end
        1: begin ep_val = 32'hFFFF_FFF0; lim_val = 8'd3; end
        2: begin ep_val = $urandom; lim_val = 8'd255; end
        3: begin ep_val = $urandom; lim_val = 8'($urandom_range(1, 8)); end
        4: begin ep_val = EP_START_RESET; lim_val = DESC_LIMIT_RESET; end
        default: begin ep_val = $urandom; lim_val = 8'd1; end
      endcase
      write_register(CFG_EP_START, ep_val);
      write_register(CFG_DESC_LIMIT, {24'($urandom), lim_val});
      if (p == 1) hold_req = 1'b1;
      lim_val = 8'd0;
      for (int target = segs_taken + segs_ignored + SEGS_PER_PHASE;
           segs_taken + segs_ignored < target; )
        send_random_list();
    end

    seg_ch.valid = 1'b0;
    while (expected_descs.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Segments merged or opened: %0d, dropped or ignored: %0d, ragged lengths: %0d",
             segs_taken, segs_ignored, ragged_lens);
    $display("Descriptors compared: %0d over %0d register writes, errors: %0d",
             descs_checked, cfg_writes, errors);
    if (errors == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
